// ===== rtl/core/ssr_pkg.sv =====
// ---------------------------------------------------------------------------
// ssr_pkg: shared types and constants
// Field widths, register indexes, status codes and the structs passed
// between the servo ramp top level, the duty sequencer and the divider.
// ---------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

	localparam int ANGLE_W    = 8;
	localparam int DELAY_W    = 16;
	localparam int TICK_W     = 32;
	localparam int RES_W      = 5;
	localparam int PULSE_US_W = 16;
	localparam int FREQ_W     = 10;
	localparam int DUTY_W     = 20;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_RES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_FREQ  = 2'd3;

	localparam logic CMD_NEW  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic STATUS_MOVING  = 1'b0;
	localparam logic STATUS_REACHED = 1'b1;

	// duty datapath widths
	localparam int PROD_W  = ANGLE_W + PULSE_US_W;  // angle * pulse span
	localparam int PER_W   = 20;                    // 1e6 / freq, and divisor width
	localparam int PULSE_W = 19;                    // pulse after scaling, span >= 90
	localparam int NUM_W   = PULSE_W + DUTY_W;      // pulse * (2^res - 1)
	localparam int CNT_W   = 6;                     // holds NUM_W

	localparam logic [RES_W-1:0]  RES_MAX     = 5'd20;
	localparam logic [PER_W-1:0]  US_PER_SEC  = 20'd1000000;
	localparam logic [DUTY_W-1:0] DUTY_SAT    = 20'hFFFFF;

	localparam logic [RES_W-1:0]      RST_DUTY_RES  = 5'd14;
	localparam logic [PULSE_US_W-1:0] RST_MIN_PULSE = 16'd500;
	localparam logic [PULSE_US_W-1:0] RST_MAX_PULSE = 16'd2500;
	localparam logic [FREQ_W-1:0]     RST_PWM_FREQ  = 10'd50;

	typedef struct packed {
		logic [RES_W-1:0]      duty_res;
		logic [PULSE_US_W-1:0] min_pulse;
		logic [PULSE_US_W-1:0] max_pulse;
		logic [FREQ_W-1:0]     pwm_freq;
	} ssr_cfg_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
		logic [NUM_W-1:0] num;
		logic [PER_W-1:0] den;
	} ssr_div_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssr_div.sv =====
// ---------------------------------------------------------------------------
// ssr_div: bit-serial restoring divider
// One quotient bit per clock. The numerator is loaded left aligned and
// nbits steps are run; the shift register then holds the quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module ssr_div
	import ssr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ssr_div_req_t req,
	output logic              done,
	output logic [NUM_W-1:0]  quo
);

	logic [NUM_W-1:0] num_q;
	logic [PER_W-1:0] rem_q;
	logic [PER_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [PER_W:0]   rem_sh;
	logic [PER_W-1:0] rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	// difference is below den_q whenever it is used, so the low bits suffice
	assign rem_sub = rem_sh[PER_W-1:0] - den_q;
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub : rem_sh[PER_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

`ifndef SYNTH
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start && cnt_q == CNT_W'(1) |=> done_q && !busy_q)
		else $error("divider missed its done pulse");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished pass");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ssr_duty.sv =====
// ---------------------------------------------------------------------------
// ssr_duty: PWM duty sequencer
// Shift-add multiply of angle by pulse span, then three divider passes:
// span scaling, PWM period, and pulse * (2^res - 1) / period.
// ---------------------------------------------------------------------------
`default_nettype none

module ssr_duty
	import ssr_pkg::*;
#(
	parameter int unsigned ANGLE_SPAN = 180
)
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ssr_cfg_t           cfg,
	input  wire logic               start,
	input  wire logic [ANGLE_W-1:0] angle,
	input  wire logic               ack,
	output logic                    done,
	output logic [DUTY_W-1:0]       duty
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MUL       = 4'd1;
	localparam logic [3:0] ST_SPAN_GO   = 4'd2;
	localparam logic [3:0] ST_SPAN_WAIT = 4'd3;
	localparam logic [3:0] ST_PER_GO    = 4'd4;
	localparam logic [3:0] ST_PER_WAIT  = 4'd5;
	localparam logic [3:0] ST_DUTY_GO   = 4'd6;
	localparam logic [3:0] ST_DUTY_WAIT = 4'd7;
	localparam logic [3:0] ST_DONE      = 4'd8;

	localparam int MCNT_W = $clog2(ANGLE_W);

	logic [3:0]          state_q;
	logic [PROD_W-1:0]   mcand_q;
	logic [ANGLE_W-1:0]  mplier_q;
	logic [PROD_W-1:0]   acc_q;
	logic [MCNT_W-1:0]   mcnt_q;
	logic [PULSE_W-1:0]  pulse_q;
	logic [PER_W-1:0]    per_q;
	logic [DUTY_W-1:0]   duty_q;
	logic                rising_q;

	ssr_div_req_t        div_req;
	logic                div_done;
	logic [NUM_W-1:0]    div_quo;

	logic                rising;
	logic [PULSE_US_W-1:0] span_us;
	logic [RES_W-1:0]    res_eff;
	logic [PER_W-1:0]    freq_eff;
	logic [NUM_W-1:0]    pulse_ext;
	logic [NUM_W-1:0]    duty_num;
	logic [PULSE_W-1:0]  q_pulse;
	logic [PULSE_W-1:0]  min_ext;

	assign rising   = cfg.max_pulse >= cfg.min_pulse;
	assign span_us  = rising ? cfg.max_pulse - cfg.min_pulse : cfg.min_pulse - cfg.max_pulse;
	assign res_eff  = (cfg.duty_res > RES_MAX) ? RES_MAX : cfg.duty_res;
	assign freq_eff = (cfg.pwm_freq == '0) ? PER_W'(1) : PER_W'(cfg.pwm_freq);
	assign pulse_ext = NUM_W'(pulse_q);
	assign duty_num  = (pulse_ext << res_eff) - pulse_ext;
	assign q_pulse   = div_quo[PULSE_W-1:0];
	assign min_ext   = PULSE_W'(cfg.min_pulse);

	always_comb begin
		div_req       = '0;
		div_req.start = 1'b0;
		case (state_q)
			ST_SPAN_GO: begin
				div_req.start = 1'b1;
				div_req.nbits = CNT_W'(PROD_W);
				div_req.num   = {acc_q, {(NUM_W-PROD_W){1'b0}}};
				div_req.den   = PER_W'(ANGLE_SPAN);
			end
			ST_PER_GO: begin
				div_req.start = 1'b1;
				div_req.nbits = CNT_W'(PER_W);
				div_req.num   = {US_PER_SEC, {(NUM_W-PER_W){1'b0}}};
				div_req.den   = freq_eff;
			end
			ST_DUTY_GO: begin
				div_req.start = 1'b1;
				div_req.nbits = CNT_W'(NUM_W);
				div_req.num   = duty_num;
				div_req.den   = per_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	ssr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						mcnt_q  <= '0;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + MCNT_W'(1);
					if (mcnt_q == MCNT_W'(ANGLE_W - 1))
						state_q <= ST_SPAN_GO;
				end
				ST_SPAN_GO:   state_q <= ST_SPAN_WAIT;
				ST_SPAN_WAIT: if (div_done) state_q <= ST_PER_GO;
				ST_PER_GO:    state_q <= ST_PER_WAIT;
				ST_PER_WAIT:  if (div_done) state_q <= ST_DUTY_GO;
				ST_DUTY_GO:   state_q <= ST_DUTY_WAIT;
				ST_DUTY_WAIT: if (div_done) state_q <= ST_DONE;
				ST_DONE:      if (ack) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					mcand_q  <= PROD_W'(span_us);
					mplier_q <= angle;
					acc_q    <= '0;
					rising_q <= rising;
				end
			end
			ST_MUL: begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[ANGLE_W-1:1]};
			end
			ST_SPAN_WAIT: begin
				if (div_done) begin
					if (rising_q)
						pulse_q <= min_ext + q_pulse;
					else
						pulse_q <= (q_pulse >= min_ext) ? '0 : min_ext - q_pulse;
				end
			end
			ST_PER_WAIT: begin
				if (div_done)
					per_q <= div_quo[PER_W-1:0];
			end
			ST_DUTY_WAIT: begin
				if (div_done)
					duty_q <= (|div_quo[NUM_W-1:DUTY_W]) ? DUTY_SAT : div_quo[DUTY_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == ST_DONE);
	assign duty = duty_q;

endmodule

`default_nettype wire

// ===== rtl/core/servo_slew_ramp_pwm_duty.sv =====
// ---------------------------------------------------------------------------
// servo_slew_ramp_pwm_duty: servo slew limiter with PWM duty output
// Steps the servo angle toward its goal on millisecond ticks and reports
// each step, or arrival, with the PWM duty for the new angle.
//
//   channel  direction  handshake             word
//   in       sink       in_valid / in_ready   command, aim_angle,
//                                             step_size, step_delay
//   out      source     out_valid / out_ready status, servo_angle,
//                                             goal_angle, duty, time_stamp
//   cfg      sink       cfg_wr_en             cfg_idx, cfg_wdata
//
// A word that produces no result leaves in_ready high. A word with a
// result holds in_ready low while the duty sequencer runs: 8 shift-add
// multiply steps, 24 + 20 + 39 bit-serial divider steps and the states
// that sequence them. The next word can be taken in the cycle after the
// result reaches the output register, even while that result still waits
// on out_ready. A full output register stalls the sequencer until
// out_ready. Reset is asynchronous and restores the register defaults
// and idle state.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_slew_ramp_pwm_duty
	import ssr_pkg::*;
#(
	parameter int unsigned ANGLE_SPAN = 180
)
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  command,
	input  wire logic [ANGLE_W-1:0]    aim_angle,
	input  wire logic [ANGLE_W-1:0]    step_size,
	input  wire logic [DELAY_W-1:0]    step_delay,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       status,
	output logic [ANGLE_W-1:0]         servo_angle,
	output logic [ANGLE_W-1:0]         goal_angle,
	output logic [DUTY_W-1:0]          duty,
	output logic [TICK_W-1:0]          time_stamp
);

	ssr_cfg_t            cfg_q;

	logic [ANGLE_W-1:0]  angle_now_q;
	logic [ANGLE_W-1:0]  angle_goal_q;
	logic [ANGLE_W-1:0]  step_amount_q;
	logic [DELAY_W-1:0]  delay_setting_q;
	logic [DELAY_W-1:0]  delay_left_q;
	logic                in_motion_q;
	logic [TICK_W-1:0]   tick_q;

	logic                busy_q;
	logic                pend_status_q;
	logic [ANGLE_W-1:0]  pend_cur_q;
	logic [ANGLE_W-1:0]  pend_goal_q;
	logic [TICK_W-1:0]   pend_ts_q;

	logic                out_valid_q;
	logic                status_q;
	logic [ANGLE_W-1:0]  cur_q;
	logic [ANGLE_W-1:0]  goal_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [TICK_W-1:0]   ts_q;

	logic [ANGLE_W-1:0]  ang_n;
	logic [ANGLE_W-1:0]  goal_n;
	logic [ANGLE_W-1:0]  amt_n;
	logic [DELAY_W-1:0]  dset_n;
	logic [DELAY_W-1:0]  dleft_n;
	logic                motion_n;
	logic [TICK_W-1:0]   tick_n;
	logic                emit;
	logic                emit_status;

	logic                in_fire;
	logic                eng_done;
	logic [DUTY_W-1:0]   eng_duty;
	logic                out_load;

	// one step toward the goal, clamped at the goal and at zero
	function automatic logic [ANGLE_W-1:0] next_angle(
		input logic [ANGLE_W-1:0] now,
		input logic [ANGLE_W-1:0] goal,
		input logic [ANGLE_W-1:0] amt
	);
		logic [ANGLE_W:0]   up;
		logic [ANGLE_W-1:0] dn;
		logic [ANGLE_W-1:0] res;
		up = {1'b0, now} + {1'b0, amt};
		dn = (now > amt) ? now - amt : '0;
		if (now < goal)
			res = (up > {1'b0, goal}) ? goal : up[ANGLE_W-1:0];
		else
			res = (dn < goal) ? goal : dn;
		return res;
	endfunction

	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;
	assign out_load = busy_q && eng_done && (!out_valid_q || out_ready);

	always_comb begin
		ang_n       = angle_now_q;
		goal_n      = angle_goal_q;
		amt_n       = step_amount_q;
		dset_n      = delay_setting_q;
		dleft_n     = delay_left_q;
		motion_n    = in_motion_q;
		tick_n      = tick_q;
		emit        = 1'b0;
		emit_status = STATUS_MOVING;
		if (command == CMD_NEW) begin
			amt_n  = step_size;
			dset_n = step_delay;
			// while moving only step size and delay change
			if (!in_motion_q) begin
				goal_n = aim_angle;
				emit   = 1'b1;
				if (angle_now_q == aim_angle) begin
					emit_status = STATUS_REACHED;
				end else begin
					ang_n    = next_angle(angle_now_q, aim_angle, step_size);
					dleft_n  = step_delay;
					motion_n = 1'b1;
				end
			end
		end else begin
			tick_n = tick_q + TICK_W'(1);
			if (in_motion_q) begin
				if (delay_left_q > DELAY_W'(1)) begin
					dleft_n = delay_left_q - DELAY_W'(1);
				end else if (angle_now_q != angle_goal_q) begin
					ang_n   = next_angle(angle_now_q, angle_goal_q, step_amount_q);
					dleft_n = delay_setting_q;
					emit    = 1'b1;
				end else begin
					dleft_n     = '0;
					motion_n    = 1'b0;
					emit        = 1'b1;
					emit_status = STATUS_REACHED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_res  <= RST_DUTY_RES;
			cfg_q.min_pulse <= RST_MIN_PULSE;
			cfg_q.max_pulse <= RST_MAX_PULSE;
			cfg_q.pwm_freq  <= RST_PWM_FREQ;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				CFG_DUTY_RES:  cfg_q.duty_res  <= cfg_wdata[RES_W-1:0];
				CFG_MIN_PULSE: cfg_q.min_pulse <= cfg_wdata[PULSE_US_W-1:0];
				CFG_MAX_PULSE: cfg_q.max_pulse <= cfg_wdata[PULSE_US_W-1:0];
				CFG_PWM_FREQ:  cfg_q.pwm_freq  <= cfg_wdata[FREQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_now_q     <= '0;
			angle_goal_q    <= '0;
			step_amount_q   <= '0;
			delay_setting_q <= '0;
			delay_left_q    <= '0;
			in_motion_q     <= 1'b0;
			tick_q          <= '0;
			busy_q          <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (in_fire) begin
				angle_now_q     <= ang_n;
				angle_goal_q    <= goal_n;
				step_amount_q   <= amt_n;
				delay_setting_q <= dset_n;
				delay_left_q    <= dleft_n;
				in_motion_q     <= motion_n;
				tick_q          <= tick_n;
				if (emit)
					busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			pend_status_q <= emit_status;
			pend_cur_q    <= ang_n;
			pend_goal_q   <= goal_n;
			pend_ts_q     <= tick_n;
		end
		if (out_load) begin
			status_q <= pend_status_q;
			cur_q    <= pend_cur_q;
			goal_q   <= pend_goal_q;
			duty_q   <= eng_duty;
			ts_q     <= pend_ts_q;
		end
	end

	ssr_duty #(
		.ANGLE_SPAN (ANGLE_SPAN)
	) u_duty (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (in_fire && emit),
		.angle  (ang_n),
		.ack    (out_load),
		.done   (eng_done),
		.duty   (eng_duty)
	);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign servo_angle = cur_q;
	assign goal_angle  = goal_q;
	assign duty        = duty_q;
	assign time_stamp  = ts_q;

endmodule

`default_nettype wire

// ===== verif/tb_servo_slew_ramp_pwm_duty.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_servo_slew_ramp_pwm_duty: self-checking bench for the servo slew ramp
// Sends command and tick words with random gaps into a result port that
// stalls at random. Every result word is checked against a bench-side model
// of the ramp and of the duty arithmetic. The run walks through several
// register settings, including the extremes.
// ---------------------------------------------------------------------------

module tb_servo_slew_ramp_pwm_duty;
	import ssr_pkg::*;

	localparam int ANGLE_SPAN  = 180;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 140;
	localparam int SEQ_LATENCY = 128;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic               cmd;
		logic [ANGLE_W-1:0] tgt;
		logic [ANGLE_W-1:0] step;
		logic [DELAY_W-1:0] dly;
	} servo_word_t;

	typedef struct packed {
		logic               st;
		logic [ANGLE_W-1:0] ang;
		logic [ANGLE_W-1:0] goal;
		logic [DUTY_W-1:0]  duty;
		logic [TICK_W-1:0]  ts;
	} servo_report_t;

	typedef struct packed {
		servo_word_t   w;
		logic          known;
		servo_report_t r;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx      = CFG_DUTY_RES;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  command      = CMD_TICK;
	logic [ANGLE_W-1:0]    aim_angle    = '0;
	logic [ANGLE_W-1:0]    step_size    = '0;
	logic [DELAY_W-1:0]    step_delay   = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic                  status;
	logic [ANGLE_W-1:0]    servo_angle;
	logic [ANGLE_W-1:0]    goal_angle;
	logic [DUTY_W-1:0]     duty;
	logic [TICK_W-1:0]     time_stamp;

	// bench copy of the ramp state and registers
	ssr_cfg_t           ramp_cfg;
	logic [ANGLE_W-1:0] ang_now, ang_goal, step_amt;
	logic [DELAY_W-1:0] dly_set, dly_left;
	logic               moving;
	logic [TICK_W-1:0]  ms_count;

	servo_report_t expected_reports[$];
	dir_row_t      dir_rows[$];
	int            n_err = 0;
	bit            send_burst = 1'b0;
	bit            fix_delay = 1'b0;

	servo_slew_ramp_pwm_duty #(.ANGLE_SPAN(ANGLE_SPAN)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.aim_angle    (aim_angle),
		.step_size    (step_size),
		.step_delay   (step_delay),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.servo_angle  (servo_angle),
		.goal_angle   (goal_angle),
		.duty         (duty),
		.time_stamp   (time_stamp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [DUTY_W-1:0] duty_of(input logic [ANGLE_W-1:0] ang);
		logic [RES_W-1:0] res;
		logic [63:0] top, pulse, drop, period, d;
		res = (ramp_cfg.duty_res > RES_MAX) ? RES_MAX : ramp_cfg.duty_res;
		top = (64'd1 << res) - 64'd1;
		if (ramp_cfg.max_pulse >= ramp_cfg.min_pulse) begin
			pulse = 64'(ramp_cfg.min_pulse) +
				64'(ang) * 64'(ramp_cfg.max_pulse - ramp_cfg.min_pulse) /
				64'(ANGLE_SPAN);
		end else begin
			// falling pulse, floored at zero
			drop = 64'(ang) * 64'(ramp_cfg.min_pulse - ramp_cfg.max_pulse) /
				64'(ANGLE_SPAN);
			pulse = (drop >= 64'(ramp_cfg.min_pulse)) ? 64'd0 : 64'(ramp_cfg.min_pulse) - drop;
		end
		period = 64'(US_PER_SEC) /
			((ramp_cfg.pwm_freq == '0) ? 64'd1 : 64'(ramp_cfg.pwm_freq));
		d = pulse * top / period;
		return (d > 64'(DUTY_SAT)) ? DUTY_SAT : d[DUTY_W-1:0];
	endfunction

	function automatic void move_one();
		logic [ANGLE_W:0]   up;
		logic [ANGLE_W-1:0] down;
		if (ang_now < ang_goal) begin
			up = {1'b0, ang_now} + {1'b0, step_amt};
			ang_now = (up > {1'b0, ang_goal}) ? ang_goal : up[ANGLE_W-1:0];
		end else begin
			down = (ang_now > step_amt) ? ang_now - step_amt : '0;
			ang_now = (down < ang_goal) ? ang_goal : down;
		end
	endfunction

	// advance the ramp by one accepted word; returns 1 when a result is due
	function automatic bit ramp_next(input servo_word_t w, output servo_report_t r);
		bit   got;
		logic st;
		got = 1'b0;
		st = STATUS_MOVING;
		if (w.cmd == CMD_NEW) begin
			step_amt = w.step;
			dly_set = w.dly;
			if (!moving) begin
				got = 1'b1;
				ang_goal = w.tgt;
				if (ang_now == ang_goal) begin
					st = STATUS_REACHED;
				end else begin
					move_one();
					dly_left = dly_set;
					moving = 1'b1;
				end
			end
		end else begin
			ms_count = ms_count + TICK_W'(1);
			if (moving && dly_left > 1) begin
				dly_left = dly_left - DELAY_W'(1);
			end else if (moving) begin
				got = 1'b1;
				if (ang_now != ang_goal) begin
					move_one();
					dly_left = dly_set;
				end else begin
					st = STATUS_REACHED;
					dly_left = '0;
					moving = 1'b0;
				end
			end
		end
		r = '{st, ang_now, ang_goal, duty_of(ang_now), ms_count};
		return got;
	endfunction

	function automatic servo_word_t pick_word();
		servo_word_t w;
		int unsigned roll;
		roll = $urandom_range(0, 9);
		w.tgt = ($urandom_range(0, 7) == 0) ? ANGLE_W'($urandom) :
			ANGLE_W'($urandom_range(0, ANGLE_SPAN));
		w.step = (roll == 0) ? '0 :
			(roll < 3) ? ANGLE_W'($urandom) : ANGLE_W'($urandom_range(1, 30));
		w.dly = DELAY_W'($urandom_range(0, 6));
		if (fix_delay) begin
			// long delay latched mid-move: overwrite it before the next step
			w.cmd = CMD_NEW;
			fix_delay = 1'b0;
		end else if (moving) begin
			w.cmd = ($urandom_range(0, 9) == 0) ? CMD_NEW : CMD_TICK;
			if (w.cmd == CMD_NEW && $urandom_range(0, 3) == 0) begin
				w.dly = DELAY_W'($urandom);
				fix_delay = 1'b1;
			end
		end else begin
			w.cmd = ($urandom_range(0, 3) == 0) ? CMD_TICK : CMD_NEW;
			// goal equal to the present angle reports at once; delay never used
			if ($urandom_range(0, 7) == 0) begin
				w.tgt = ang_now;
				w.dly = DELAY_W'($urandom);
			end
		end
		return w;
	endfunction

	task automatic plan(input logic cmd, input int tgt, step, dly);
		dir_row_t row;
		row.w = '{cmd, ANGLE_W'(tgt), ANGLE_W'(step), DELAY_W'(dly)};
		row.known = 1'b0;
		row.r = '0;
		dir_rows.push_back(row);
	endtask

	task automatic plan_known(input logic cmd, input int tgt, step, dly,
			input logic st, input int ang, goal, dty, ts);
		dir_row_t row;
		row.w = '{cmd, ANGLE_W'(tgt), ANGLE_W'(step), DELAY_W'(dly)};
		row.known = 1'b1;
		row.r = '{st, ANGLE_W'(ang), ANGLE_W'(goal), DUTY_W'(dty), TICK_W'(ts)};
		dir_rows.push_back(row);
	endtask

	// called on a falling edge, returns on a falling edge
	task automatic put_word(input servo_word_t w, input logic known,
			input servo_report_t known_r);
		int gap;
		servo_report_t r;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		command    <= w.cmd;
		aim_angle  <= w.tgt;
		step_size  <= w.step;
		step_delay <= w.dly;
		do @(posedge clk); while (!in_ready);
		if (ramp_next(w, r))
			expected_reports.push_back(known ? known_r : r);
		@(negedge clk);
	endtask

	task automatic load_regs(input int p);
		ssr_cfg_t c;
		case (p)
			1: c = '{5'd20, 16'd0, 16'hFFFF, 10'd1000};
			2: c = '{5'd1, 16'hFFFF, 16'd0, 10'd1};
			3: c = '{5'd0, 16'd1000, 16'd2000, 10'd0};
			4: c = '{5'd31, 16'hFFFF, 16'hFFFF, 10'd1023};
			5: c = '{5'd14, 16'd2500, 16'd500, 10'd50};
			default: c = '{RES_W'($urandom), PULSE_US_W'($urandom),
				PULSE_US_W'($urandom), FREQ_W'($urandom_range(0, 1023))};
		endcase
		ramp_cfg = c;
		cfg_wr_en <= 1'b1;
		cfg_idx   <= CFG_DUTY_RES;
		cfg_wdata <= CFG_DATA_W'(c.duty_res);
		@(negedge clk);
		cfg_idx   <= CFG_MIN_PULSE;
		cfg_wdata <= c.min_pulse;
		@(negedge clk);
		cfg_idx   <= CFG_MAX_PULSE;
		cfg_wdata <= c.max_pulse;
		@(negedge clk);
		cfg_idx   <= CFG_PWM_FREQ;
		cfg_wdata <= CFG_DATA_W'(c.pwm_freq);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : result_sink
		int            gap, n_seen;
		bit            burst;
		servo_report_t got, e;
		n_seen = 0;
		burst = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			// long hold-off so the block backs up and stalls its input
			if (n_seen == 30 || n_seen == 500) begin
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
			gap = burst ? 0 : $urandom_range(0, 15);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{status, servo_angle, goal_angle, duty, time_stamp};
			n_seen++;
			if (expected_reports.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected word: st=%0d ang=%0d goal=%0d duty=%0d ts=%0d",
						got.st, got.ang, got.goal, got.duty, got.ts);
			end else begin
				e = expected_reports.pop_front();
				if (got.st !== e.st || got.ang !== e.ang || got.goal !== e.goal ||
						got.duty !== e.duty || got.ts !== e.ts) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp st=%0d ang=%0d goal=%0d duty=%0d ts=%0d %s",
							e.st, e.ang, e.goal, e.duty, e.ts,
							$sformatf("got st=%0d ang=%0d goal=%0d duty=%0d ts=%0d",
							got.st, got.ang, got.goal, got.duty, got.ts));
				end
			end
			@(negedge clk);
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		servo_report_t no_report;
		no_report = '0;
		ramp_cfg = '{RST_DUTY_RES, RST_MIN_PULSE, RST_MAX_PULSE, RST_PWM_FREQ};
		ang_now = '0;
		ang_goal = '0;
		step_amt = '0;
		dly_set = '0;
		dly_left = '0;
		moving = 1'b0;
		ms_count = '0;

		// goal equal to angle after reset: reports reached at once
		plan_known(CMD_NEW, 0, 0, 0, STATUS_REACHED, 0, 0, 409, 0);
		plan(CMD_TICK, 0, 0, 0);
		// upward overshoot clamps to goal
		plan_known(CMD_NEW, 180, 255, 0, STATUS_MOVING, 180, 180, 2047, 1);
		plan_known(CMD_TICK, 0, 0, 0, STATUS_REACHED, 180, 180, 2047, 2);
		plan(CMD_NEW, 0, 100, 2);
		// commands mid-move: step and delay only, goal kept
		plan(CMD_NEW, 0, 0, 65535);
		plan(CMD_NEW, 255, 255, 1);
		plan(CMD_TICK, 0, 0, 0);
		plan(CMD_TICK, 0, 0, 0);
		plan(CMD_TICK, 0, 0, 0);
		// zero step repeats moving until a nonzero step arrives
		plan(CMD_NEW, 255, 0, 0);
		plan(CMD_TICK, 0, 0, 0);
		plan(CMD_TICK, 0, 0, 0);
		plan(CMD_NEW, 7, 200, 0);
		plan(CMD_TICK, 0, 0, 0);
		plan(CMD_TICK, 0, 0, 0);
		plan(CMD_TICK, 0, 0, 0);
		plan(CMD_NEW, 255, 255, 65535);
		// downward step floors at goal
		plan(CMD_NEW, 90, 255, 1);
		plan(CMD_TICK, 0, 0, 0);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			put_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].r);

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				in_valid <= 1'b0;
				while (expected_reports.size() != 0) @(posedge clk);
				repeat (SEQ_LATENCY) @(negedge clk);
				load_regs(p);
			end
			repeat (PHASE_WORDS)
				put_word(pick_word(), 1'b0, no_report);
		end

		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (4 * SEQ_LATENCY) @(posedge clk);
		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ssr_pkg.sv
rtl/core/ssr_div.sv
rtl/core/ssr_duty.sv
rtl/core/servo_slew_ramp_pwm_duty.sv
verif/tb_servo_slew_ramp_pwm_duty.sv
